// ----- rtl/alu8f_pkg.sv -----
package alu8f_pkg;

  typedef logic [4:0] op_t;

  localparam op_t OP_ADD   = 5'd0;
  localparam op_t OP_ADC   = 5'd1;
  localparam op_t OP_SUB   = 5'd2;
  localparam op_t OP_SBC   = 5'd3;
  localparam op_t OP_AND   = 5'd4;
  localparam op_t OP_XOR   = 5'd5;
  localparam op_t OP_OR    = 5'd6;
  localparam op_t OP_CP    = 5'd7;
  localparam op_t OP_RLC   = 5'd8;
  localparam op_t OP_RRC   = 5'd9;
  localparam op_t OP_RL    = 5'd10;
  localparam op_t OP_RR    = 5'd11;
  localparam op_t OP_SLA   = 5'd12;
  localparam op_t OP_SRA   = 5'd13;
  localparam op_t OP_SWAP  = 5'd14;
  localparam op_t OP_SRL   = 5'd15;
  localparam op_t OP_BIT   = 5'd16;
  localparam op_t OP_RES   = 5'd17;
  localparam op_t OP_SET   = 5'd18;
  localparam op_t OP_INC   = 5'd19;
  localparam op_t OP_DEC   = 5'd20;
  localparam op_t OP_DAA   = 5'd21;
  localparam op_t OP_CPL   = 5'd22;
  localparam op_t OP_SCF   = 5'd23;
  localparam op_t OP_CCF   = 5'd24;
  localparam op_t OP_RLCA  = 5'd25;
  localparam op_t OP_RRCA  = 5'd26;
  localparam op_t OP_RLA   = 5'd27;
  localparam op_t OP_RRA   = 5'd28;
  localparam op_t OP_ADD16 = 5'd29;
  localparam op_t OP_SPADD = 5'd30;

  // Rotate/shift selector codes, shared by the CB group and the accumulator rotates.
  typedef logic [2:0] rot_sel_t;

  localparam rot_sel_t ROT_RLC  = 3'd0;
  localparam rot_sel_t ROT_RRC  = 3'd1;
  localparam rot_sel_t ROT_RL   = 3'd2;
  localparam rot_sel_t ROT_RR   = 3'd3;
  localparam rot_sel_t ROT_SLA  = 3'd4;
  localparam rot_sel_t ROT_SRA  = 3'd5;
  localparam rot_sel_t ROT_SWAP = 3'd6;
  localparam rot_sel_t ROT_SRL  = 3'd7;

  localparam logic [7:0]  DAA_HI_ADJ   = 8'h60;
  localparam logic [7:0]  DAA_LO_ADJ   = 8'h06;
  localparam logic [7:0]  DAA_HI_LIMIT = 8'h99;
  localparam logic [3:0]  DAA_LO_LIMIT = 4'h9;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    flags_t      flags_in;
  } item_t;

  typedef struct packed {
    logic [15:0] result;
    flags_t      flags_out;
  } result_t;

  // Returns {carry out, rotated byte}.
  function automatic logic [8:0] rot8(input rot_sel_t sel, input logic [7:0] v,
                                      input logic cin);
    logic [8:0] r;
    unique case (sel)
      ROT_RLC:  r = {v[7], v[6:0], v[7]};
      ROT_RRC:  r = {v[0], v[0], v[7:1]};
      ROT_RL:   r = {v[7], v[6:0], cin};
      ROT_RR:   r = {v[0], cin, v[7:1]};
      ROT_SLA:  r = {v[7], v[6:0], 1'b0};
      ROT_SRA:  r = {v[0], v[7], v[7:1]};
      ROT_SWAP: r = {1'b0, v[3:0], v[7:4]};
      ROT_SRL:  r = {v[0], 1'b0, v[7:1]};
      default:  r = {1'b0, v};
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/alu_with_flags_8bit_unit.sv -----
// 8-bit CPU ALU with Z N H C flags, two register stages deep.
// Input channel: in_valid/in_ready carry an operation code, the accumulator
// (or HL/SP), a second operand, a bit index and the incoming flags. A transfer
// happens on a rising edge with in_valid and in_ready both high.
// Result channel: out_valid/out_ready carry the result word and the new flags,
// one result for every input item, in order.
// An item taken at a transfer is held in the input register, goes through the
// ALU and is registered in the result register, where it shows on out_valid.
// Throughput is one item per cycle while out_ready is high: each register
// refills as its item moves on; the ALU between is one pass of adders and muxes.
// When the receiver stalls, the result register holds its value; the input
// register can still take one more item, and only with both full does in_ready
// drop. in_ready follows out_ready combinationally through both stages.
// Synchronous active-low reset empties both stages; no result is pending after
// reset and there is no other state.
module alu_with_flags_8bit_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_op,
  input  logic [15:0] in_operand_a,
  input  logic [15:0] in_operand_b,
  input  logic [2:0]  in_bit_index,
  input  logic [3:0]  in_flags_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_result,
  output logic [3:0]  out_flags_out
);

  alu8f_pkg::item_t   in_item;
  alu8f_pkg::item_t   s1_item;
  logic               s1_valid;
  logic               s2_ready;
  alu8f_pkg::result_t s1_res;
  alu8f_pkg::result_t s2_res;

  assign in_item.op        = in_op;
  assign in_item.operand_a = in_operand_a;
  assign in_item.operand_b = in_operand_b;
  assign in_item.bit_index = in_bit_index;
  assign in_item.flags_in  = in_flags_in;

  alu8f_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_item  (in_item),
    .dn_valid (s1_valid),
    .dn_ready (s2_ready),
    .dn_item  (s1_item)
  );

  alu8f_core u_core (
    .item (s1_item),
    .res  (s1_res)
  );

  alu8f_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s2_ready),
    .up_res   (s1_res),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_res   (s2_res)
  );

  assign out_result    = s2_res.result;
  assign out_flags_out = s2_res.flags_out;

`ifndef SYNTHESIS
  // A stalled input means both stages are full.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid && out_valid))
    else $error("input stalled with an empty stage");

  // An item leaving the input register always lands in the result register.
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && s2_ready) |=> out_valid)
    else $error("item lost between stages");

  // A full pipeline with a stalled receiver keeps the pending item.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && out_valid && !out_ready) |=> (s1_valid && $stable(s1_item)))
    else $error("pending item dropped during a stall");
`endif

endmodule

// ----- rtl/alu8f_in_stage.sv -----
module alu8f_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  alu8f_pkg::item_t     up_item,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output alu8f_pkg::item_t     dn_item
);

  logic             valid_r;
  alu8f_pkg::item_t item_r;

  // The stage refills in the same cycle that its item moves on.
  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= up_item;
    end
  end

endmodule

// ----- rtl/alu8f_core.sv -----
module alu8f_core (
  input  alu8f_pkg::item_t   item,
  output alu8f_pkg::result_t res
);

  logic [7:0]       a;
  logic [7:0]       b;
  logic             k_add;
  logic             k_sub;
  logic [8:0]       add9;
  logic [4:0]       add_h5;
  logic [7:0]       sub8;
  logic             sub_c;
  logic             sub_h;
  logic [8:0]       rot_cb;
  logic [8:0]       rot_acc;
  logic [7:0]       bit_mask;
  logic [7:0]       inc8;
  logic [7:0]       dec8;
  logic [7:0]       daa8;
  logic             daa_c;
  logic [16:0]      add17;
  logic [12:0]      add_h13;
  logic [15:0]      sp_sum;
  logic [4:0]       sp_h5;
  logic [8:0]       sp_c9;
  logic [7:0]       logic8;
  alu8f_pkg::flags_t f;
  alu8f_pkg::flags_t fo;
  logic [15:0]      r;

  assign a = item.operand_a[7:0];
  assign b = item.operand_b[7:0];
  assign f = item.flags_in;

  assign k_add  = (item.op == alu8f_pkg::OP_ADC) && f.c;
  assign k_sub  = (item.op == alu8f_pkg::OP_SBC) && f.c;
  assign add9   = {1'b0, a} + {1'b0, b} + {8'd0, k_add};
  assign add_h5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, k_add};
  assign sub8   = a - b - {7'd0, k_sub};
  assign sub_c  = ({1'b0, b} + {8'd0, k_sub}) > {1'b0, a};
  assign sub_h  = ({1'b0, b[3:0]} + {4'd0, k_sub}) > {1'b0, a[3:0]};

  assign rot_cb  = alu8f_pkg::rot8(item.op[2:0], b, f.c);
  assign rot_acc = alu8f_pkg::rot8(3'(item.op - alu8f_pkg::OP_RLCA), a, f.c);

  assign bit_mask = 8'd1 << item.bit_index;
  assign inc8     = b + 8'd1;
  assign dec8     = b - 8'd1;

  // Decimal adjust: after a subtraction only undo, after an addition also detect overflow.
  always_comb begin
    daa8  = a;
    daa_c = f.c;
    if (f.n) begin
      if (f.c) daa8 = daa8 - alu8f_pkg::DAA_HI_ADJ;
      if (f.h) daa8 = daa8 - alu8f_pkg::DAA_LO_ADJ;
    end else begin
      if (f.c || (a > alu8f_pkg::DAA_HI_LIMIT)) begin
        daa8  = daa8 + alu8f_pkg::DAA_HI_ADJ;
        daa_c = 1'b1;
      end
      if (f.h || (a[3:0] > alu8f_pkg::DAA_LO_LIMIT)) daa8 = daa8 + alu8f_pkg::DAA_LO_ADJ;
    end
  end

  assign add17   = {1'b0, item.operand_a} + {1'b0, item.operand_b};
  assign add_h13 = {1'b0, item.operand_a[11:0]} + {1'b0, item.operand_b[11:0]};
  assign sp_sum  = item.operand_a + {{8{b[7]}}, b};
  assign sp_h5   = {1'b0, item.operand_a[3:0]} + {1'b0, b[3:0]};
  assign sp_c9   = {1'b0, item.operand_a[7:0]} + {1'b0, b};

  always_comb begin
    unique case (item.op)
      alu8f_pkg::OP_AND: logic8 = a & b;
      alu8f_pkg::OP_XOR: logic8 = a ^ b;
      default:           logic8 = a | b;
    endcase
  end

  always_comb begin
    r  = item.operand_a;
    fo = f;
    unique case (item.op)
      alu8f_pkg::OP_ADD, alu8f_pkg::OP_ADC: begin
        r  = {8'd0, add9[7:0]};
        fo = '{z: (add9[7:0] == 8'd0), n: 1'b0, h: add_h5[4], c: add9[8]};
      end
      alu8f_pkg::OP_SUB, alu8f_pkg::OP_SBC: begin
        r  = {8'd0, sub8};
        fo = '{z: (sub8 == 8'd0), n: 1'b1, h: sub_h, c: sub_c};
      end
      alu8f_pkg::OP_CP: begin
        r  = {8'd0, a};
        fo = '{z: (sub8 == 8'd0), n: 1'b1, h: sub_h, c: sub_c};
      end
      alu8f_pkg::OP_AND: begin
        r  = {8'd0, logic8};
        fo = '{z: (logic8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      alu8f_pkg::OP_XOR, alu8f_pkg::OP_OR: begin
        r  = {8'd0, logic8};
        fo = '{z: (logic8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      alu8f_pkg::OP_RLC, alu8f_pkg::OP_RRC, alu8f_pkg::OP_RL, alu8f_pkg::OP_RR,
      alu8f_pkg::OP_SLA, alu8f_pkg::OP_SRA, alu8f_pkg::OP_SWAP, alu8f_pkg::OP_SRL: begin
        r  = {8'd0, rot_cb[7:0]};
        fo = '{z: (rot_cb[7:0] == 8'd0), n: 1'b0, h: 1'b0, c: rot_cb[8]};
      end
      alu8f_pkg::OP_BIT: begin
        r  = {8'd0, b};
        fo = '{z: ((b & bit_mask) == 8'd0), n: 1'b0, h: 1'b1, c: f.c};
      end
      alu8f_pkg::OP_RES: r = {8'd0, b & ~bit_mask};
      alu8f_pkg::OP_SET: r = {8'd0, b | bit_mask};
      alu8f_pkg::OP_INC: begin
        r  = {8'd0, inc8};
        fo = '{z: (inc8 == 8'd0), n: 1'b0, h: (b[3:0] == 4'hF), c: f.c};
      end
      alu8f_pkg::OP_DEC: begin
        r  = {8'd0, dec8};
        fo = '{z: (dec8 == 8'd0), n: 1'b1, h: (b[3:0] == 4'h0), c: f.c};
      end
      alu8f_pkg::OP_DAA: begin
        r  = {8'd0, daa8};
        fo = '{z: (daa8 == 8'd0), n: f.n, h: 1'b0, c: daa_c};
      end
      alu8f_pkg::OP_CPL: begin
        r  = {8'd0, ~a};
        fo = '{z: f.z, n: 1'b1, h: 1'b1, c: f.c};
      end
      alu8f_pkg::OP_SCF: begin
        r  = {8'd0, a};
        fo = '{z: f.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      alu8f_pkg::OP_CCF: begin
        r  = {8'd0, a};
        fo = '{z: f.z, n: 1'b0, h: 1'b0, c: !f.c};
      end
      alu8f_pkg::OP_RLCA, alu8f_pkg::OP_RRCA, alu8f_pkg::OP_RLA, alu8f_pkg::OP_RRA: begin
        r  = {8'd0, rot_acc[7:0]};
        fo = '{z: 1'b0, n: 1'b0, h: 1'b0, c: rot_acc[8]};
      end
      alu8f_pkg::OP_ADD16: begin
        r  = add17[15:0];
        fo = '{z: f.z, n: 1'b0, h: add_h13[12], c: add17[16]};
      end
      alu8f_pkg::OP_SPADD: begin
        r  = sp_sum;
        fo = '{z: 1'b0, n: 1'b0, h: sp_h5[4], c: sp_c9[8]};
      end
      // The one unused code passes the accumulator and the flags through.
      default: begin
        r  = item.operand_a;
        fo = f;
      end
    endcase
  end

  assign res.result    = r;
  assign res.flags_out = fo;

endmodule

// ----- rtl/alu8f_out_stage.sv -----
module alu8f_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  alu8f_pkg::result_t   up_res,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output alu8f_pkg::result_t   dn_res
);

  logic               valid_r;
  alu8f_pkg::result_t res_r;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res_r <= up_res;
    end
  end

endmodule
